### rtl/core/uer_pkg.sv
package uer_pkg;

  localparam int COUNT_BITS_DEF = 16;
  localparam int DIST_W         = 24;
  localparam int SCALE_W        = 24;
  localparam int TMR_W          = 4;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 24;
  localparam int IN_TDATA_W     = 8;
  localparam int OUT_TDATA_W    = 32;

  localparam logic [DIST_W-1:0] DistMax = '1;

  localparam logic [CFG_IDX_W-1:0] CFG_TRIG_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIG_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE     = 2'd3;

  localparam logic [TMR_W-1:0]   TRIG_LOW_RST  = 4'd3;
  localparam logic [TMR_W-1:0]   TRIG_HIGH_RST = 4'd10;
  localparam logic [TMR_W-1:0]   SAMPLE_RST    = 4'd2;
  localparam logic [SCALE_W-1:0] SCALE_RST     = 24'd3147;

  localparam logic [TMR_W-1:0] MIN_TRIG   = 4'd1;
  localparam logic [TMR_W-1:0] MIN_SAMPLE = 4'd2;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_TRIG_LOW  = 3'd1,
    PH_TRIG_HIGH = 3'd2,
    PH_WAIT_RISE = 3'd3,
    PH_MEASURE   = 3'd4
  } phase_t;

  typedef struct packed {
    logic [TMR_W-1:0]   trig_low;
    logic [TMR_W-1:0]   trig_high;
    logic [TMR_W-1:0]   sample_period;
    logic [SCALE_W-1:0] scale;
  } cfg_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              done;
    logic              busy;
    logic              trigger;
  } res_t;

endpackage

### rtl/core/ultrasonic_echo_ranger.sv
// A result beat is registered as its input beat is taken and is offered in the next cycle.
// Throughput: one beat per cycle while the output is accepted; the single output register frees in the
// same cycle it is drained, so input and output run together without bubbles.
// Reset (rst_n low, synchronous): sequencer idle, timer and count cleared,
// last distance zero, configuration back to its defaults, output empty.
module ultrasonic_echo_ranger #(
  parameter int COUNT_BITS = uer_pkg::COUNT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [uer_pkg::IN_TDATA_W-1:0]    in_tdata,   // [0] start_req, [1] echo
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [uer_pkg::OUT_TDATA_W-1:0]   out_tdata,  // [0] trigger, [1] busy_res,
                                                        // [2] done_res, [26:3] distance_q8
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [uer_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [uer_pkg::CFG_DATA_W-1:0]    cfg_data
);

  uer_pkg::cfg_t cfg;
  uer_pkg::res_t res;
  logic          room;
  logic          accept;

  assign cfg_ready = 1'b1;
  assign in_tready = room;
  assign accept    = in_tvalid && room;

  uer_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  uer_seq #(
    .COUNT_BITS (COUNT_BITS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .start_req (in_tdata[0]),
    .echo      (in_tdata[1]),
    .cfg       (cfg),
    .res       (res)
  );

  uer_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (accept),
    .res        (res),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .room       (room)
  );

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2] |-> !out_tdata[1] && !out_tdata[0])
    else $error("done beat with busy or trigger set");

  a_trig_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tdata[1])
    else $error("trigger high outside a measurement");

  a_room: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output register");

  a_dist_hold: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !res.done && $past(accept) |-> res.distance == $past(res.distance))
    else $error("distance changed without done");

endmodule

### rtl/core/uer_cfg.sv
module uer_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             wr_en,
  input  logic [uer_pkg::CFG_IDX_W-1:0]    wr_index,
  input  logic [uer_pkg::CFG_DATA_W-1:0]   wr_data,
  output uer_pkg::cfg_t                    cfg
);

  uer_pkg::cfg_t cfg_r;
  uer_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        uer_pkg::CFG_TRIG_LOW:  cfg_nxt.trig_low      = wr_data[uer_pkg::TMR_W-1:0];
        uer_pkg::CFG_TRIG_HIGH: cfg_nxt.trig_high     = wr_data[uer_pkg::TMR_W-1:0];
        uer_pkg::CFG_SAMPLE:    cfg_nxt.sample_period = wr_data[uer_pkg::TMR_W-1:0];
        uer_pkg::CFG_SCALE:     cfg_nxt.scale         = wr_data[uer_pkg::SCALE_W-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.trig_low      <= uer_pkg::TRIG_LOW_RST;
      cfg_r.trig_high     <= uer_pkg::TRIG_HIGH_RST;
      cfg_r.sample_period <= uer_pkg::SAMPLE_RST;
      cfg_r.scale         <= uer_pkg::SCALE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### rtl/core/uer_seq.sv
module uer_seq #(
  parameter int COUNT_BITS = uer_pkg::COUNT_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           accept,
  input  logic           start_req,
  input  logic           echo,
  input  uer_pkg::cfg_t  cfg,
  output uer_pkg::res_t  res
);

  localparam int PROD_W = COUNT_BITS + uer_pkg::SCALE_W;
  localparam int Q8_W   = PROD_W - 8;

  uer_pkg::phase_t                 phase_r, phase_nxt, phase_in;
  logic [uer_pkg::TMR_W-1:0]       timer_r, timer_nxt, timer_in, timer_inc;
  logic [COUNT_BITS-1:0]           count_r, count_nxt, count_sat_inc;
  logic [uer_pkg::DIST_W-1:0]      dist_r, dist_nxt;
  logic [uer_pkg::TMR_W-1:0]       low_eff, high_eff, sample_eff;
  logic [PROD_W-1:0]               product;
  logic [Q8_W-1:0]                 q8;
  logic                            trig, busy, done;

  assign low_eff    = (cfg.trig_low < uer_pkg::MIN_TRIG) ? uer_pkg::MIN_TRIG : cfg.trig_low;
  assign high_eff   = (cfg.trig_high < uer_pkg::MIN_TRIG) ? uer_pkg::MIN_TRIG : cfg.trig_high;
  assign sample_eff = (cfg.sample_period < uer_pkg::MIN_SAMPLE) ? uer_pkg::MIN_SAMPLE
                                                                : cfg.sample_period;

  assign product       = PROD_W'(count_r) * PROD_W'(cfg.scale);
  assign q8            = product[PROD_W-1:8];
  assign count_sat_inc = (&count_r) ? count_r : count_r + COUNT_BITS'(1);

  always_comb begin
    phase_in = phase_r;
    timer_in = timer_r;
    if (phase_r == uer_pkg::PH_IDLE && start_req) begin
      phase_in = uer_pkg::PH_TRIG_LOW;
      timer_in = '0;
    end
    timer_inc = timer_in + uer_pkg::TMR_W'(1);

    phase_nxt = phase_in;
    timer_nxt = timer_in;
    count_nxt = count_r;
    dist_nxt  = dist_r;
    trig      = 1'b0;
    busy      = 1'b0;
    done      = 1'b0;

    case (phase_in)
      uer_pkg::PH_IDLE: begin
        timer_nxt = timer_in;
      end
      uer_pkg::PH_TRIG_LOW: begin
        busy      = 1'b1;
        timer_nxt = timer_inc;
        if (timer_inc >= low_eff) begin
          phase_nxt = uer_pkg::PH_TRIG_HIGH;
          timer_nxt = '0;
        end
      end
      uer_pkg::PH_TRIG_HIGH: begin
        busy      = 1'b1;
        trig      = 1'b1;
        timer_nxt = timer_inc;
        if (timer_inc >= high_eff) begin
          phase_nxt = uer_pkg::PH_WAIT_RISE;
          timer_nxt = '0;
        end
      end
      uer_pkg::PH_WAIT_RISE: begin
        busy = 1'b1;
        if (echo) begin
          count_nxt = COUNT_BITS'(1);
          phase_nxt = uer_pkg::PH_MEASURE;
          timer_nxt = '0;
        end
      end
      uer_pkg::PH_MEASURE: begin
        busy      = 1'b1;
        timer_nxt = timer_inc;
        if (timer_inc >= sample_eff) begin
          timer_nxt = '0;
          if (echo) begin
            count_nxt = count_sat_inc;
          end else begin
            dist_nxt  = (q8 > Q8_W'(uer_pkg::DistMax)) ? uer_pkg::DistMax
                                                       : q8[uer_pkg::DIST_W-1:0];
            done      = 1'b1;
            busy      = 1'b0;
            phase_nxt = uer_pkg::PH_IDLE;
          end
        end
      end
      default: begin
        phase_nxt = uer_pkg::PH_IDLE;
        timer_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= uer_pkg::PH_IDLE;
      timer_r <= '0;
      count_r <= '0;
      dist_r  <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      timer_r <= timer_nxt;
      count_r <= count_nxt;
      dist_r  <= dist_nxt;
    end
  end

  assign res.trigger  = trig;
  assign res.busy     = busy;
  assign res.done     = done;
  assign res.distance = dist_nxt;

endmodule

### rtl/core/uer_out.sv
module uer_out (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               load,
  input  uer_pkg::res_t                      res,
  input  logic                               out_tready,
  output logic                               out_tvalid,
  output logic [uer_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                               room
);

  localparam int RES_W = $bits(uer_pkg::res_t);

  logic          valid_r, valid_nxt;
  uer_pkg::res_t data_r;

  assign room = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {{(uer_pkg::OUT_TDATA_W-RES_W){1'b0}}, data_r};

endmodule

### test/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 1000;
  localparam int RANDOM_BEATS = 400;

  logic clk = 1'b0;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [uer_pkg::IN_TDATA_W-1:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [uer_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic cfg_valid;
  logic cfg_ready;
  logic [uer_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [uer_pkg::CFG_DATA_W-1:0] cfg_data;

  uer_pkg::cfg_t ranger_cfg;
  uer_pkg::phase_t seq_phase;
  logic [uer_pkg::TMR_W-1:0] seq_timer;
  logic [uer_pkg::COUNT_BITS_DEF-1:0] echo_count;
  logic [uer_pkg::DIST_W-1:0] held_distance;

  uer_pkg::res_t pending_readings[$];
  uer_pkg::res_t front_reading;
  int mismatches = 0;
  int sent_beats = 0;
  int quiet_cycles = 0;
  int hold_len = 0;
  int stall_left = 0;
  bit idle_on = 1'b0;

  ultrasonic_echo_ranger dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [0] start_req, [1] echo
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // [0] trigger, [1] busy_res, [2] done_res, [26:3] distance_q8
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5ns clk = ~clk;

  function automatic logic coin();
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic logic [uer_pkg::TMR_W-1:0] floor_to(logic [uer_pkg::TMR_W-1:0] v,
                                                         logic [uer_pkg::TMR_W-1:0] lo);
    return (v < lo) ? lo : v;
  endfunction

  function automatic uer_pkg::res_t range_tick(logic start, logic echo);
    uer_pkg::res_t r;
    logic [39:0] product;
    r = '0;
    if (seq_phase == uer_pkg::PH_IDLE && start) begin
      seq_phase = uer_pkg::PH_TRIG_LOW;
      seq_timer = '0;
    end
    case (seq_phase)
      uer_pkg::PH_TRIG_LOW: begin
        r.busy = 1'b1;
        seq_timer++;
        if (seq_timer >= floor_to(ranger_cfg.trig_low, uer_pkg::MIN_TRIG)) begin
          seq_phase = uer_pkg::PH_TRIG_HIGH;
          seq_timer = '0;
        end
      end
      uer_pkg::PH_TRIG_HIGH: begin
        r.busy = 1'b1;
        r.trigger = 1'b1;
        seq_timer++;
        if (seq_timer >= floor_to(ranger_cfg.trig_high, uer_pkg::MIN_TRIG)) begin
          seq_phase = uer_pkg::PH_WAIT_RISE;
          seq_timer = '0;
        end
      end
      uer_pkg::PH_WAIT_RISE: begin
        r.busy = 1'b1;
        if (echo) begin
          echo_count = uer_pkg::COUNT_BITS_DEF'(1);
          seq_phase = uer_pkg::PH_MEASURE;
          seq_timer = '0;
        end
      end
      uer_pkg::PH_MEASURE: begin
        r.busy = 1'b1;
        seq_timer++;
        if (seq_timer >= floor_to(ranger_cfg.sample_period, uer_pkg::MIN_SAMPLE)) begin
          seq_timer = '0;
          if (echo) begin
            if (echo_count != '1) echo_count++;
          end else begin
            product = 40'(echo_count) * 40'(ranger_cfg.scale);
            held_distance = (product[39:8] > 32'(uer_pkg::DistMax)) ? uer_pkg::DistMax
                                                                    : product[31:8];
            r.done = 1'b1;
            r.busy = 1'b0;
            seq_phase = uer_pkg::PH_IDLE;
          end
        end
      end
      default: begin
        seq_phase = uer_pkg::PH_IDLE;
        seq_timer = '0;
      end
    endcase
    r.distance = held_distance;
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    if (mismatches < 40)
      $display("ERROR @%0t %s: got %0h want %0h", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_readings.size() == 0) begin
        report("beat with nothing pending", out_tdata, '0);
      end else begin
        front_reading = pending_readings.pop_front();
        if (out_tdata[0] !== front_reading.trigger)
          report("trigger", 32'(out_tdata[0]), 32'(front_reading.trigger));
        if (out_tdata[1] !== front_reading.busy)
          report("busy_res", 32'(out_tdata[1]), 32'(front_reading.busy));
        if (out_tdata[2] !== front_reading.done)
          report("done_res", 32'(out_tdata[2]), 32'(front_reading.done));
        if (out_tdata[26:3] !== front_reading.distance)
          report("distance_q8", 32'(out_tdata[26:3]), 32'(front_reading.distance));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_len > 0) begin
        out_tready <= 1'b0;
        hold_len--;
      end else if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        stall_left = $urandom_range(0, 4);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic send_item(input logic start, input logic echo);
    uer_pkg::res_t want;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= uer_pkg::IN_TDATA_W'({echo, start});
    do @(posedge clk); while (!in_tready);
    want = range_tick(start, echo);
    pending_readings.push_back(want);
    sent_beats++;
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_readings.size() != 0);
  endtask

  task automatic write_reg(input logic [uer_pkg::CFG_IDX_W-1:0] idx,
                           input logic [uer_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      uer_pkg::CFG_TRIG_LOW:  ranger_cfg.trig_low = val[uer_pkg::TMR_W-1:0];
      uer_pkg::CFG_TRIG_HIGH: ranger_cfg.trig_high = val[uer_pkg::TMR_W-1:0];
      uer_pkg::CFG_SAMPLE:    ranger_cfg.sample_period = val[uer_pkg::TMR_W-1:0];
      uer_pkg::CFG_SCALE:     ranger_cfg.scale = val[uer_pkg::SCALE_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic write_all(input int low_us, input int high_us, input int period_us,
                           input logic [uer_pkg::SCALE_W-1:0] scale);
    write_reg(uer_pkg::CFG_TRIG_LOW, uer_pkg::CFG_DATA_W'(low_us));
    write_reg(uer_pkg::CFG_TRIG_HIGH, uer_pkg::CFG_DATA_W'(high_us));
    write_reg(uer_pkg::CFG_SAMPLE, uer_pkg::CFG_DATA_W'(period_us));
    write_reg(uer_pkg::CFG_SCALE, uer_pkg::CFG_DATA_W'(scale));
  endtask

  task automatic finish_ranging(input bit noisy);
    while (seq_phase != uer_pkg::PH_IDLE)
      send_item(noisy ? coin() : 1'b0, seq_phase == uer_pkg::PH_WAIT_RISE);
  endtask

  task automatic run_ranging(input int rise_delay, input int echo_ticks, input bit noisy);
    send_item(1'b1, coin());
    while (seq_phase == uer_pkg::PH_TRIG_LOW || seq_phase == uer_pkg::PH_TRIG_HIGH)
      send_item(noisy ? coin() : 1'b0, coin());
    repeat (rise_delay) send_item(noisy ? coin() : 1'b0, 1'b0);
    repeat (echo_ticks)
      send_item(noisy ? coin() : 1'b0,
                (noisy && $urandom_range(0, 7) == 0) ? 1'b0 : 1'b1);
    finish_ranging(noisy);
  endtask

  task automatic test_default_ranging();
    send_item(1'b0, 1'b1);
    send_item(1'b0, 1'b0);
    run_ranging(0, 1, 0);
    run_ranging(3, 9, 0);
    settle();
  endtask

  task automatic test_register_extremes();
    write_all(0, 0, 0, uer_pkg::DistMax);
    run_ranging(0, 600, 0);
    settle();
    write_all(1, 1, 1, '0);
    run_ranging(2, 10, 0);
    settle();
    write_all(15, 15, 15, 24'd1);
    run_ranging(1, 40, 0);
    settle();
    write_all(7, 8, 3, 24'hA5A5A5);
    run_ranging(0, 20, 0);
    settle();
  endtask

  task automatic test_lost_echo();
    write_all(2, 4, 2, uer_pkg::SCALE_RST);
    run_ranging(150, 3, 0);
    settle();
  endtask

  task automatic test_output_backpressure();
    // hold off the output while the input keeps coming
    hold_len = 60;
    run_ranging(2, 40, 1);
    run_ranging(0, 30, 1);
    settle();
  endtask

  task automatic test_random_ranging();
    int base;
    int runs;
    logic [uer_pkg::SCALE_W-1:0] scale;
    base = sent_beats;
    runs = 0;
    while (sent_beats - base < RANDOM_BEATS) begin
      if (runs % 5 == 0) begin
        settle();
        case ($urandom_range(0, 3))
          0: scale = uer_pkg::DistMax;
          1: scale = uer_pkg::SCALE_W'($urandom_range(0, 'h2000));
          2: scale = uer_pkg::SCALE_W'($urandom);
          default: scale = uer_pkg::SCALE_RST;
        endcase
        write_all($urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 15), scale);
      end
      idle_on = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(0, 4)) send_item(coin(), coin());
      finish_ranging(1'b1);
      if ($urandom_range(0, 9) == 0)
        run_ranging($urandom_range(0, 6), $urandom_range(100, 600), $urandom_range(0, 3) != 0);
      else
        run_ranging($urandom_range(0, 6), $urandom_range(0, 50), $urandom_range(0, 3) != 0);
      runs++;
    end
    settle();
    idle_on = 1'b1;
  endtask

  task automatic test_back_to_back();
    idle_on = 1'b0;
    write_all(2, 3, 2, 24'h00C4B);
    repeat (6) run_ranging($urandom_range(0, 3), $urandom_range(0, 30), 1);
    settle();
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    ranger_cfg = '{trig_low: uer_pkg::TRIG_LOW_RST, trig_high: uer_pkg::TRIG_HIGH_RST,
                   sample_period: uer_pkg::SAMPLE_RST, scale: uer_pkg::SCALE_RST};
    seq_phase = uer_pkg::PH_IDLE;
    seq_timer = '0;
    echo_count = '0;
    held_distance = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    idle_on = 1'b1;
    test_default_ranging();
    test_register_extremes();
    test_lost_echo();
    test_output_backpressure();
    test_random_ranging();
    test_back_to_back();
    settle();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/uer_pkg.sv
rtl/core/uer_cfg.sv
rtl/core/uer_seq.sv
rtl/core/uer_out.sv
rtl/core/ultrasonic_echo_ranger.sv
test/tb.sv
